/* sv/cflick_pkg.sv */
// ----------------------------------------------------------------------------
// cflick_pkg
// Shared types, constants and colour arithmetic for the candle flicker
// generator.
// ----------------------------------------------------------------------------
package cflick_pkg;

  // Input operation codes.
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_RESEED = 1'b1;

  // Generator constants.
  localparam logic [31:0] SEED_A         = 32'hf1ea5eed;
  localparam int          DISCARD_ROUNDS = 20;
  localparam int          ROUND_W        = $clog2(DISCARD_ROUNDS);

  // LED limits: the count saturates to the smaller of the two.
  localparam int          MAX_LEDS     = 8;
  localparam int          RESULT_LIMIT = 8;
  localparam logic [3:0]  LED_LIMIT    =
    4'((MAX_LEDS < RESULT_LIMIT) ? MAX_LEDS : RESULT_LIMIT);

  // Fixed colour terms.
  localparam logic [7:0]  RED_LEVEL  = 8'd128;
  localparam logic [6:0]  GREEN_BASE = 7'd64;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_seed;
    logic       round;
    logic       load_out;
    logic [2:0] led_index;
    logic       last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free;
  } status_t;

  // Number of set bits in a 32-bit word, by parallel field sums.
  function automatic logic [5:0] ones_count(input logic [31:0] v);
    logic [31:0] s1;
    logic [31:0] s2;
    logic [31:0] s3;
    logic [7:0]  total;
    s1 = v - ((v >> 1) & 32'h55555555);
    s2 = (s1 & 32'h33333333) + ((s1 >> 2) & 32'h33333333);
    s3 = (s2 + (s2 >> 4)) & 32'h0f0f0f0f;
    total = s3[7:0] + s3[15:8] + s3[23:16] + s3[31:24];
    return total[5:0];
  endfunction

  // Flicker level 1 << (8 - k), with k = min(8, |16 - p| / 2 + 4).
  function automatic logic [4:0] flicker_level(input logic [5:0] p);
    logic [5:0] spread;
    logic [4:0] half;
    logic [2:0] shift;
    spread = (p >= 6'd16) ? (p - 6'd16) : (6'd16 - p);
    half   = spread[5:1];
    shift  = (half >= 5'd4) ? 3'd0 : 3'(5'd4 - half);
    return 5'd1 << shift;
  endfunction

endpackage

/* sv/candle_flicker_generator.sv */
// A reseed loads the generator on its transfer and then runs 20 discard rounds while busy.
// A tick that emits nothing only advances the prescaler; a fourth tick steps through each
// LED: a generator round, then the colour into the output register once the slot frees.
// Reseeds and LED draws share the single round unit: one round per cycle.
// Reset clears the generator words, the prescaler and the output valid flag, and sets led_count to 1.
// ----------------------------------------------------------------------------
// candle_flicker_generator
// Candle-like flicker colours drawn from a 128-bit small-fast generator,
// one colour per configured LED on every fourth tick.
// ----------------------------------------------------------------------------
module candle_flicker_generator (
  input  logic        clk,
  input  logic        rst,
  // Input channel: a tick or a reseed.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [31:0] seed,
  // Configuration channel: the LED count.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  // Result channel: one colour per transfer.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  led_index,
  output logic [7:0]  red,
  output logic [6:0]  green,
  output logic [2:0]  blue,
  output logic        last
);

  // The controller accepts one input item at a time. A reseed loads the
  // generator in the cycle of its transfer and then runs the discard rounds
  // on the shared round unit. Ticks go through a divide-by-four prescaler;
  // on the fourth the controller steps through the LEDs, drawing one word
  // per LED. The result register is a stage of its own, so the block may
  // take the next input while the last colour of a step still waits to be
  // transferred; a following colour is loaded only when the slot frees.

  cflick_pkg::cmd_t    cmd;
  cflick_pkg::status_t status;

  cflick_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the generator state and the result register.
  cflick_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .seed      (seed),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .led_index (led_index),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .last      (last)
  );

endmodule

/* sv/cflick_ctrl.sv */
// ----------------------------------------------------------------------------
// cflick_ctrl
// Sequencer for the candle flicker generator: input handshake, prescaler,
// discard round count and per-LED stepping.
// ----------------------------------------------------------------------------
module cflick_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  opcode,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [3:0]            cfg_data,
  input  cflick_pkg::status_t   status,
  output cflick_pkg::cmd_t      cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SEED  = 4'b0010,
    ST_ROUND = 4'b0100,
    ST_LOAD  = 4'b1000
  } state_t;

  state_t                           state;
  state_t                           state_next;
  logic [cflick_pkg::ROUND_W-1:0]   round_cnt;
  logic [cflick_pkg::ROUND_W-1:0]   round_cnt_next;
  logic [1:0]                       prescale;
  logic [1:0]                       prescale_next;
  logic [2:0]                       led_cnt;
  logic [2:0]                       led_cnt_next;
  logic [3:0]                       led_count;
  logic [3:0]                       leds;
  logic                             last_led;

  // Effective number of LEDs for one step.
  assign leds     = (led_count > cflick_pkg::LED_LIMIT) ? cflick_pkg::LED_LIMIT : led_count;
  assign last_led = (({1'b0, led_cnt} + 4'd1) == leds);

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_next     = state;
    round_cnt_next = round_cnt;
    prescale_next  = prescale;
    led_cnt_next   = led_cnt;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (opcode == cflick_pkg::OP_RESEED) begin
            state_next     = ST_SEED;
            round_cnt_next = '0;
          end else if (prescale != 2'd3) begin
            prescale_next = prescale + 2'd1;
          end else begin
            prescale_next = 2'd0;
            led_cnt_next  = 3'd0;
            if (leds != 4'd0) begin
              state_next = ST_ROUND;
            end
          end
        end
      end
      ST_SEED: begin
        round_cnt_next = round_cnt + 1'b1;
        if (round_cnt == cflick_pkg::ROUND_W'(cflick_pkg::DISCARD_ROUNDS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_ROUND: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (status.slot_free) begin
          if (last_led) begin
            state_next = ST_IDLE;
          end else begin
            led_cnt_next = led_cnt + 3'd1;
            state_next   = ST_ROUND;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.load_seed = (state == ST_IDLE) && in_valid && (opcode == cflick_pkg::OP_RESEED);
    cmd.round     = (state == ST_SEED) || (state == ST_ROUND);
    cmd.load_out  = (state == ST_LOAD) && status.slot_free;
    cmd.led_index = led_cnt;
    cmd.last      = last_led;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      round_cnt <= '0;
      prescale  <= 2'd0;
      led_cnt   <= 3'd0;
      led_count <= 4'd1;
    end else begin
      state     <= state_next;
      round_cnt <= round_cnt_next;
      prescale  <= prescale_next;
      led_cnt   <= led_cnt_next;
      if (cfg_valid) begin
        led_count <= cfg_data;
      end
    end
  end

endmodule

/* sv/cflick_dp.sv */
// ----------------------------------------------------------------------------
// cflick_dp
// Datapath for the candle flicker generator: the four generator words, one
// round per cycle, the colour arithmetic and the output register.
// ----------------------------------------------------------------------------
module cflick_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  cflick_pkg::cmd_t      cmd,
  output cflick_pkg::status_t   status,
  input  logic [31:0]           seed,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            led_index,
  output logic [7:0]            red,
  output logic [6:0]            green,
  output logic [2:0]            blue,
  output logic                  last
);

  logic [31:0] word_a;
  logic [31:0] word_b;
  logic [31:0] word_c;
  logic [31:0] word_d;
  logic [31:0] e_term;
  logic [31:0] a_next;
  logic [4:0]  level;

  // One generator round.
  assign e_term = word_a - {word_b[4:0], word_b[31:5]};
  assign a_next = word_b ^ {word_c[14:0], word_c[31:15]};

  // Colour from the most recent drawn word, held in word_d.
  assign level = cflick_pkg::flicker_level(cflick_pkg::ones_count(word_d));

  assign status.slot_free = !out_valid || out_ready;
  assign red              = cflick_pkg::RED_LEVEL;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_a <= '0;
      word_b <= '0;
      word_c <= '0;
      word_d <= '0;
    end else if (cmd.load_seed) begin
      word_a <= cflick_pkg::SEED_A;
      word_b <= seed;
      word_c <= seed;
      word_d <= seed;
    end else if (cmd.round) begin
      word_a <= a_next;
      word_b <= word_c + word_d;
      word_c <= word_d + e_term;
      word_d <= e_term + a_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      led_index <= cmd.led_index;
      green     <= cflick_pkg::GREEN_BASE + {2'b00, level};
      blue      <= level[4:2];
      last      <= cmd.last;
    end
  end

endmodule
